/* hdl/dshot_tlm_pkg.sv */
// ----------------------------------------------------------------------------
// dshot_tlm_pkg
// Shared types, constants and the GCR lookup for the DShot telemetry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dshot_tlm_pkg;

    // Field widths
    localparam int TICK_W      = 15;
    localparam int CFG_W       = 8;
    localparam int FRAME_W     = 21;
    localparam int POS_W       = 5;
    localparam int READING_W   = 27;
    localparam int COUNT_W     = 32;
    localparam int KIND_W      = 4;
    localparam int STATUS_W    = 2;

    // Shared divider geometry
    localparam int DIV_W       = 27;
    localparam int DIVISOR_W   = 16;
    localparam int STEP_W      = 5;
    localparam int NUMER_W     = 20;

    // Decoding constants
    localparam logic [POS_W-1:0]   POS_START   = 5'd20;
    localparam int                 ERPM_SCALE  = 1000000 * 60 / 100;
    localparam int                 RPM_SCALE   = 200;
    localparam logic [7:0]         GCR_BAD     = 8'hFF;
    localparam logic [11:0]        PAYLOAD_ALL = 12'hFFF;

    // Configuration defaults and register indexes
    localparam logic [CFG_W-1:0] BIT_TICKS_RESET = 8'd12;
    localparam logic [CFG_W-1:0] POLES_RESET     = 8'd14;
    localparam logic             REG_BIT_TICKS   = 1'b0;
    localparam logic             REG_POLES       = 1'b1;

    localparam int MAX_SYMBOLS_DEF = 64;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV0,
        S_DIV1,
        S_FRAME,
        S_ERPM,
        S_RPM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    steps;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic                 crc_ok;
        logic                 is_erpm;
        logic                 zero_erpm;
        logic [KIND_W-1:0]    kind;
        logic [7:0]           data_byte;
        logic [DIVISOR_W-1:0] period;
        logic [NUMER_W-1:0]   numer;
    } t_frame_info;

    // Five-bit GCR code to nibble; invalid codes give all ones
    function automatic logic [7:0] gcr_lookup(input logic [4:0] code);
        logic [7:0] v;
        case (code)
            5'd9:    v = 8'd9;
            5'd10:   v = 8'd10;
            5'd11:   v = 8'd11;
            5'd13:   v = 8'd13;
            5'd14:   v = 8'd14;
            5'd15:   v = 8'd15;
            5'd18:   v = 8'd2;
            5'd19:   v = 8'd3;
            5'd21:   v = 8'd5;
            5'd22:   v = 8'd6;
            5'd23:   v = 8'd7;
            5'd25:   v = 8'd0;
            5'd26:   v = 8'd8;
            5'd27:   v = 8'd1;
            5'd29:   v = 8'd4;
            5'd30:   v = 8'd12;
            default: v = GCR_BAD;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/dshot_tlm_div.sv */
// ----------------------------------------------------------------------------
// dshot_tlm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot_tlm_div
    import dshot_tlm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DIV_W-1:0]     r_acc;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;
    logic [STEP_W-1:0]    r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // Dividend is left aligned; quotient bits fill in from the bottom
    assign shifted = {r_rem, r_acc[DIV_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* hdl/dshot_tlm_gcr.sv */
// ----------------------------------------------------------------------------
// dshot_tlm_gcr
// Frame word to payload: edge decode, GCR, checksum and eRPM period.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot_tlm_gcr
    import dshot_tlm_pkg::*;
(
    input  wire logic [FRAME_W-1:0] i_frame_bits,
    output t_frame_info             o_info
);

    logic [FRAME_W-1:0]   w;
    logic [27:0]          dec_acc;
    logic [15:0]          dec;
    logic [11:0]          payload;
    logic [3:0]           want;
    logic [DIVISOR_W-1:0] period;

    // Transitions carry the ones
    assign w = i_frame_bits ^ (i_frame_bits >> 1);

    // Invalid codes spill all-ones into the next nibble, as the checksum expects
    always_comb begin
        dec_acc = '0;
        for (int i = 0; i < 4; i++) begin
            dec_acc = dec_acc | ({20'b0, gcr_lookup(w[5*i +: 5])} << (4*i));
        end
    end

    assign dec     = dec_acc[15:0];
    assign payload = dec[15:4];
    assign want    = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
    assign period  = DIVISOR_W'({7'b0, payload[8:0]} << payload[11:9]);

    assign o_info.crc_ok    = dec[3:0] == want;
    assign o_info.is_erpm   = payload[8] || (payload[11:8] == 4'd0);
    assign o_info.zero_erpm = (payload == PAYLOAD_ALL) || (period == '0);
    assign o_info.kind      = payload[11:8];
    assign o_info.data_byte = payload[7:0];
    assign o_info.period    = period;
    assign o_info.numer     = NUMER_W'(ERPM_SCALE) + NUMER_W'(period >> 1);

endmodule

`default_nettype wire

/* hdl/dshot_telemetry_decoder.sv */
// ----------------------------------------------------------------------------
// dshot_telemetry_decoder
// Bidirectional DShot GCR telemetry decoder: pulse symbols in, decoded
// eRPM (as RPM) or extended telemetry readings out, one per frame.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | content
//  ----------+-----+------------------------+------------------------------------
//  s_axis    | in  | tvalid/tready          | one pulse symbol, tlast = frame end
//  m_axis    | out | tvalid/tready          | one result per frame end
//  cfg       | in  | write enable, no wait  | 0: bit_ticks, 1: motor_poles
//
//  A symbol below the symbol limit runs two 15-step divisions of the phase
//  tick counts by bit_ticks on the shared one-bit-per-cycle divider, each
//  ending in a done strobe, and then returns to idle; symbols past the limit
//  skip them. A frame-end symbol adds the decode state and, for an eRPM
//  reading, a 20-step and a 27-step division before the result is written
//  to the output register.
//  Reset is synchronous and active low; it clears the frame, the counters
//  and the configuration to defaults. The input side is stalled while a
//  symbol is being worked on; a result waiting in the output register only
//  stalls the block when the next result is ready to go out.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot_telemetry_decoder
    import dshot_tlm_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    // Symbol input
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [31:0]      i_s_axis_tdata,  // [14:0] first_ticks, [29:15] second_ticks
    input  wire logic             i_s_axis_tuser,  // [0] first_level
    input  wire logic             i_s_axis_tlast,  // frame_end

    // Result output
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [95:0]           o_m_axis_tdata,  // [1:0] status, [28:2] reading,
                                                   // [60:29] good_total, [92:61] bad_total
    output logic [4:0]            o_m_axis_tuser,  // [0] is_erpm, [4:1] telem_kind

    // Configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int SYM_W = $clog2(MAX_SYMBOLS + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_bit_ticks;
    logic [CFG_W-1:0]     r_poles;

    logic [FRAME_W-1:0]   r_frame_bits, n_frame_bits;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_pos_neg, n_pos_neg;
    logic [SYM_W-1:0]     r_sym_cnt;
    logic [COUNT_W-1:0]   r_good, r_bad;

    logic                 r_level;
    logic [TICK_W-1:0]    r_t1;
    logic                 r_end;

    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_res_erpm;
    logic [KIND_W-1:0]    r_res_kind;
    logic [READING_W-1:0] r_res_reading;

    logic                 r_out_valid;
    logic [95:0]          r_out_tdata;
    logic [4:0]           r_out_tuser;

    // ------------------------------------------------------------------
    // Sequencer strobes
    // ------------------------------------------------------------------
    logic        accept;
    logic        active;
    logic        short_frame;
    logic        apply;
    logic        apply_set;
    logic        count_inc;
    logic        frame_done;
    logic        rpm_done;
    logic        load_out;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_frame_info info;

    logic [CFG_W-1:0]     bt_eff;
    logic [CFG_W-1:0]     poles_eff;
    logic [READING_W-1:0] rpm_product;

    // A zero register value behaves as one
    assign bt_eff    = (r_bit_ticks == '0) ? CFG_W'(1) : r_bit_ticks;
    assign poles_eff = (r_poles == '0) ? CFG_W'(1) : r_poles;

    assign accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign active      = r_sym_cnt < SYM_W'(MAX_SYMBOLS);
    assign short_frame = r_sym_cnt <= SYM_W'(1);

    // eRPM * 200 fits in 27 bits, feeds the pole division
    assign rpm_product = READING_W'({7'b0, div_rsp.quot[NUMER_W-1:0]} * READING_W'(RPM_SCALE));

    dshot_tlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dshot_tlm_gcr u_gcr (
        .i_frame_bits (r_frame_bits),
        .o_info       (info)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (active) begin
                        n_state = S_DIV0;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_FRAME;
                    end
                end
            end
            S_DIV0: begin
                if (div_rsp.done) begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    n_state = r_end ? S_FRAME : S_IDLE;
                end
            end
            S_FRAME: begin
                if (!short_frame && info.crc_ok && info.is_erpm && !info.zero_erpm) begin
                    n_state = S_ERPM;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ERPM: begin
                if (div_rsp.done) begin
                    n_state = S_RPM;
                end
            end
            S_RPM: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: divider requests and datapath strobes
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready  = 1'b0;
        div_req          = '0;
        div_req.divisor  = {8'b0, bt_eff};
        apply            = 1'b0;
        apply_set        = 1'b0;
        count_inc        = 1'b0;
        frame_done       = 1'b0;
        rpm_done         = 1'b0;
        load_out         = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid && active) begin
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(TICK_W);
                    div_req.dividend = {i_s_axis_tdata[TICK_W-1:0], (DIV_W-TICK_W)'(0)};
                end
            end
            S_DIV0: begin
                if (div_rsp.done) begin
                    // first phase is high when the level bit is set
                    apply            = 1'b1;
                    apply_set        = r_level;
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(TICK_W);
                    div_req.dividend = {r_t1, (DIV_W-TICK_W)'(0)};
                end
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    apply     = 1'b1;
                    apply_set = !r_level;
                    count_inc = 1'b1;
                end
            end
            S_FRAME: begin
                frame_done = 1'b1;
                if (!short_frame && info.crc_ok && info.is_erpm && !info.zero_erpm) begin
                    // rounded 600000 / period
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(NUMER_W);
                    div_req.dividend = {info.numer, (DIV_W-NUMER_W)'(0)};
                    div_req.divisor  = info.period;
                end
            end
            S_ERPM: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(DIV_W);
                    div_req.dividend = rpm_product;
                    div_req.divisor  = {8'b0, poles_eff};
                end
            end
            S_RPM: begin
                rpm_done = div_rsp.done;
            end
            S_OUT: begin
                load_out = !r_out_valid || i_m_axis_tready;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Phase application: count bits, then set or skip them
    // ------------------------------------------------------------------
    logic [DIVISOR_W-1:0] nbits;
    logic                 round_up;
    logic                 overrun;
    logic [POS_W-1:0]     low_pos;
    logic [FRAME_W-1:0]   set_mask;

    // Round up when remainder > bit_ticks - 4 (also covers bit_ticks < 4)
    assign round_up = ({1'b0, div_rsp.rem[CFG_W-1:0]} + 9'd4) > {1'b0, bt_eff};
    assign nbits    = {1'b0, div_rsp.quot[TICK_W-1:0]} + DIVISOR_W'(round_up);
    assign overrun  = nbits > {11'b0, r_pos};
    assign low_pos  = overrun ? '0 : (r_pos - nbits[POS_W-1:0] + 1'b1);

    always_comb begin
        for (int b = 0; b < FRAME_W; b++) begin
            set_mask[b] = apply_set && !r_pos_neg && (nbits != '0)
                          && (POS_W'(b) <= r_pos) && (POS_W'(b) >= low_pos);
        end
    end

    always_comb begin
        n_frame_bits = r_frame_bits;
        n_pos        = r_pos;
        n_pos_neg    = r_pos_neg;
        if (apply && !r_pos_neg) begin
            n_frame_bits = r_frame_bits | set_mask;
            if (overrun) begin
                // below bit zero: park there, drop the rest of the frame's bits
                n_pos_neg = 1'b1;
            end else begin
                n_pos = r_pos - nbits[POS_W-1:0];
            end
        end
        if (frame_done) begin
            n_frame_bits = '0;
            n_pos        = POS_START;
            n_pos_neg    = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bit_ticks  <= BIT_TICKS_RESET;
            r_poles      <= POLES_RESET;
            r_frame_bits <= '0;
            r_pos        <= POS_START;
            r_pos_neg    <= 1'b0;
            r_sym_cnt    <= '0;
            r_good       <= '0;
            r_bad        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_frame_bits <= n_frame_bits;
            r_pos        <= n_pos;
            r_pos_neg    <= n_pos_neg;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BIT_TICKS: r_bit_ticks <= i_cfg_wdata;
                    REG_POLES:     r_poles     <= i_cfg_wdata;
                    default:       ;
                endcase
            end

            if (count_inc) begin
                r_sym_cnt <= r_sym_cnt + 1'b1;
            end

            if (frame_done) begin
                r_sym_cnt <= '0;
                if (!short_frame) begin
                    if (info.crc_ok) begin
                        r_good <= r_good + 1'b1;
                    end else begin
                        r_bad <= r_bad + 1'b1;
                    end
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_level <= i_s_axis_tuser;
            r_t1    <= i_s_axis_tdata[2*TICK_W-1:TICK_W];
            r_end   <= i_s_axis_tlast;
        end

        if (frame_done) begin
            if (short_frame) begin
                r_res_status  <= STATUS_SHORT;
                r_res_erpm    <= 1'b0;
                r_res_kind    <= '0;
                r_res_reading <= '0;
            end else if (!info.crc_ok) begin
                r_res_status  <= STATUS_CRC;
                r_res_erpm    <= 1'b0;
                r_res_kind    <= '0;
                r_res_reading <= '0;
            end else begin
                r_res_status <= STATUS_OK;
                r_res_erpm   <= info.is_erpm;
                // zero reading stands for eRPM unless the divisions below run
                r_res_kind    <= info.is_erpm ? '0 : info.kind;
                r_res_reading <= info.is_erpm ? '0 : READING_W'(info.data_byte);
            end
        end

        if (rpm_done) begin
            r_res_reading <= div_rsp.quot;
        end

        if (load_out) begin
            r_out_tdata <= {3'b0, r_bad, r_good, r_res_reading, r_res_status};
            r_out_tuser <= {r_res_kind, r_res_erpm};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Divider completions only arrive while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV0 || r_state == S_DIV1 ||
                          r_state == S_ERPM || r_state == S_RPM))
        else $error("divider completion outside a wait state");

    // Frame state is restored before the result goes out
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_sym_cnt == '0 && !r_pos_neg &&
                                r_pos == POS_START && r_frame_bits == '0))
        else $error("frame state not cleared at result time");

    // Symbol count saturates at the frame limit
    a_sym_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym_cnt <= SYM_W'(MAX_SYMBOLS))
        else $error("symbol count beyond limit");

    // A blocked result slot holds the sequencer in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
